// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the cell code block.
// Each macro takes a label, the clock, the active-low reset and the property parts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SPCC_ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SPCC_ASSERT_IMPLIES(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ----- hw/rtl/spcc_pkg.sv -----
// Package for the spherical point to cell code block: widths, cell types, stage word.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package spcc_pkg;

  localparam int unsigned CoordW           = 32;  // latitude, longitude, radius
  localparam int unsigned LevelW           = 5;
  localparam int unsigned DigitW           = 3;
  localparam int unsigned ChildDigits      = 16;
  localparam int unsigned ChildW           = DigitW * ChildDigits;
  localparam int unsigned MaxLevelsDefault = 16;

  // Angle residual scaled so the half width is always 2^29; bounded by 2^30.
  localparam int unsigned AngleW = 31;
  // Radius residual scaled so the half width is always max_radius.
  localparam int unsigned RadW   = CoordW + 1;

  localparam logic [CoordW-1:0] QuarterTurn = 32'h4000_0000;
  localparam logic [AngleW-1:0] AngleHalf   = 31'h2000_0000;

  localparam logic [DigitW-1:0] DigitInnerBase = 3'd3;

  typedef enum logic [1:0] {
    CellNormal,
    CellLatDegen,
    CellSphereDegen
  } cell_type_e;

  typedef struct packed {
    logic [DigitW-1:0] octant;
    logic [AngleW-1:0] lat_res;
    logic [AngleW-1:0] lon_res;
    logic [RadW-1:0]   rad_res;
    logic              beyond;   // radius above max_radius: always outer
    cell_type_e        ctype;
    logic [LevelW-1:0] lvl;
    logic [ChildW-1:0] digits;
  } spcc_stage_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spcc_intf.sv -----
// Channel interfaces of the cell code block: point input, code output, config write.
// Depends on spcc_pkg for field widths.
`default_nettype none

interface spcc_point_if import spcc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] latitude;
  logic signed [CoordW-1:0] longitude;
  logic        [CoordW-1:0] radius;
  logic        [LevelW-1:0] level;

  modport source (output valid, latitude, longitude, radius, level, input ready);
  modport sink   (input valid, latitude, longitude, radius, level, output ready);
endinterface

interface spcc_code_if import spcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DigitW-1:0] octant;
  logic [ChildW-1:0] child_digits;
  logic [LevelW-1:0] digit_count;

  modport source (output valid, octant, child_digits, digit_count, input ready);
  modport sink   (input valid, octant, child_digits, digit_count, output ready);
endinterface

interface spcc_cfg_if import spcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/spcc_prep.sv -----
// Entry stage: sign split, magnitudes, saturation, octant digit, initial residuals.
// Depends on spcc_pkg and the point interface in spcc_intf.sv.
`default_nettype none

module spcc_prep import spcc_pkg::*; #(
  parameter int unsigned MAX_LEVELS = MaxLevelsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [CoordW-1:0] max_radius_i,
  spcc_point_if.sink       point,
  output spcc_stage_t      stage_o,
  output logic             valid_o,
  input  wire logic        ready_i
);

  localparam logic [LevelW-1:0] MaxLvl = LevelW'(MAX_LEVELS);

  logic              valid_q;
  spcc_stage_t       stage_q, stage_d;
  logic              lat_neg, lon_neg, lon_far;
  logic [CoordW-1:0] lat_mag, lon_mag, lat_sat, lon_off;

  assign point.ready = !valid_q || ready_i;

  always_comb begin
    lat_neg = point.latitude[CoordW-1];
    lon_neg = point.longitude[CoordW-1];
    lat_mag = lat_neg ? CoordW'(-point.latitude) : CoordW'(point.latitude);
    lon_mag = lon_neg ? CoordW'(-point.longitude) : CoordW'(point.longitude);
    lat_sat = (lat_mag > QuarterTurn) ? QuarterTurn : lat_mag;
    lon_far = lon_mag > QuarterTurn;
    lon_off = lon_far ? (lon_mag - QuarterTurn) : lon_mag;

    stage_d.octant  = {lat_neg, lon_neg, lon_far};
    stage_d.lat_res = lat_sat[AngleW-1:0];
    stage_d.lon_res = lon_off[AngleW-1:0];
    stage_d.rad_res = {point.radius, 1'b0};
    stage_d.beyond  = point.radius > max_radius_i;
    stage_d.ctype   = CellSphereDegen;
    stage_d.lvl     = (point.level > MaxLvl) ? MaxLvl : point.level;
    stage_d.digits  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (point.ready) begin
      valid_q <= point.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (point.valid && point.ready) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- hw/rtl/spcc_level.sv -----
// One subdivision level: radius, latitude and longitude halving plus the cell type rules.
// Depends on spcc_pkg; one instance per level in the top level.
`default_nettype none

module spcc_level import spcc_pkg::*; #(
  parameter int unsigned LEVEL = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CoordW-1:0] max_radius_i,
  input  wire spcc_stage_t       stage_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  output spcc_stage_t            stage_o,
  output logic                   valid_o,
  input  wire logic              ready_i
);

  localparam logic [LevelW-1:0] LevelIdx = LevelW'(LEVEL);

  logic              valid_q;
  spcc_stage_t       stage_q, stage_d, stage_w;
  logic              active, outer, low_lat, low_lon, lat_upd, lon_upd;
  logic [RadW-1:0]   half_rad, rad_sub;
  logic [AngleW-1:0] lat_sub, lon_sub;
  logic [DigitW-1:0] digit, base;
  cell_type_e        ctype_next;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    active   = LevelIdx < stage_i.lvl;
    half_rad = {1'b0, max_radius_i};
    outer    = stage_i.beyond || (stage_i.rad_res > half_rad);
    low_lat  = stage_i.lat_res < AngleHalf;
    low_lon  = stage_i.lon_res < AngleHalf;
    rad_sub  = outer ? (stage_i.rad_res - half_rad) : stage_i.rad_res;
    lat_sub  = low_lat ? stage_i.lat_res : (stage_i.lat_res - AngleHalf);
    lon_sub  = low_lon ? stage_i.lon_res : (stage_i.lon_res - AngleHalf);
    base     = outer ? '0 : DigitInnerBase;

    digit      = '0;
    lat_upd    = 1'b0;
    lon_upd    = 1'b0;
    ctype_next = stage_i.ctype;
    case (stage_i.ctype)
      CellNormal: begin
        digit   = {~outer, ~low_lat, ~low_lon};
        lat_upd = 1'b1;
        lon_upd = 1'b1;
      end
      CellLatDegen: begin
        lat_upd = 1'b1;
        if (low_lat) begin
          digit      = base + {2'b00, ~low_lon};
          lon_upd    = 1'b1;
          ctype_next = CellNormal;
        end else begin
          digit = base + 3'd2;
        end
      end
      CellSphereDegen: begin
        if (!outer) begin
          digit = DigitInnerBase;
        end else if (low_lat) begin
          digit      = {2'b00, ~low_lon};
          lat_upd    = 1'b1;
          lon_upd    = 1'b1;
          ctype_next = CellNormal;
        end else begin
          digit      = 3'd2;
          lat_upd    = 1'b1;
          ctype_next = CellLatDegen;
        end
      end
      default: begin
        digit = '0;
      end
    endcase

    stage_d = stage_i;
    if (active) begin
      // Rescale by two so the half width stays fixed at the next level.
      stage_d.rad_res = {rad_sub[RadW-2:0], 1'b0};
      if (lat_upd) begin
        stage_d.lat_res = {lat_sub[AngleW-2:0], 1'b0};
      end
      if (lon_upd) begin
        stage_d.lon_res = {lon_sub[AngleW-2:0], 1'b0};
      end
      stage_d.ctype = ctype_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  generate
    if (LEVEL < ChildDigits) begin : g_store
      always_comb begin
        stage_w = stage_d;
        stage_w.digits[DigitW*LEVEL +: DigitW] = active ? digit : '0;
      end
    end else begin : g_drop
      // Digits past the code word are dropped.
      assign stage_w = stage_d;
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_w;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- hw/rtl/spherical_point_to_cell_code_top.sv -----
// Channel     Dir  Words                                   Handshake
// point_i     in   latitude, longitude, radius, level      valid/ready
// code_o      out  octant, child_digits, digit_count       valid/ready
// cfg_i       in   max_radius                              valid/ready, always ready
//
// One point enters per cycle while no stall holds the pipeline; its code passes through
// the entry stage and then one register stage per level.
// Each stage holds its word while the next is full; a stall backs up stage by stage.
// Reset clears the stage valid bits and sets max_radius to all ones.
//
// Top level of the spherical point to cell code block.
// Depends on spcc_pkg, spcc_intf, spcc_prep, spcc_level and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spherical_point_to_cell_code_top import spcc_pkg::*; #(
  parameter int unsigned MAX_LEVELS = MaxLevelsDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spcc_point_if.sink  point_i,
  spcc_code_if.source code_o,
  spcc_cfg_if.sink    cfg_i
);

  logic [CoordW-1:0]   max_radius_q;
  logic [MAX_LEVELS:0] vld;
  logic [MAX_LEVELS:0] rdy;
  spcc_stage_t         stg [MAX_LEVELS+1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_radius_q <= '1;
    end else if (cfg_i.valid) begin
      max_radius_q <= cfg_i.data;
    end
  end

  spcc_prep #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_radius_i(max_radius_q),
    .point       (point_i),
    .stage_o     (stg[0]),
    .valid_o     (vld[0]),
    .ready_i     (rdy[0])
  );

  generate
    for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_level
      spcc_level #(
        .LEVEL(k)
      ) u_level (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .max_radius_i(max_radius_q),
        .stage_i     (stg[k]),
        .valid_i     (vld[k]),
        .ready_o     (rdy[k]),
        .stage_o     (stg[k+1]),
        .valid_o     (vld[k+1]),
        .ready_i     (rdy[k+1])
      );
    end
  endgenerate

  assign rdy[MAX_LEVELS]     = code_o.ready;
  assign code_o.valid        = vld[MAX_LEVELS];
  assign code_o.octant       = stg[MAX_LEVELS].octant;
  assign code_o.child_digits = stg[MAX_LEVELS].digits;
  assign code_o.digit_count  = stg[MAX_LEVELS].lvl;

  // Input can only back up when the output word is held.
  `SPCC_ASSERT_IMPLIES(a_stall_src, clk_i, rst_ni, !point_i.ready, code_o.valid && !code_o.ready, "input stalled without output stall")
  `SPCC_ASSERT_IMPLIES(a_count_max, clk_i, rst_ni, code_o.valid, code_o.digit_count <= LevelW'(MAX_LEVELS), "digit count above level limit")
  `SPCC_ASSERT_IMPLIES(a_unused_zero, clk_i, rst_ni, code_o.valid, (code_o.child_digits >> (DigitW * code_o.digit_count)) == '0, "digits set past digit count")
  // The first level starts sphere-degenerate, so its digit never exceeds three.
  `SPCC_ASSERT_ALWAYS(a_first_digit, clk_i, rst_ni, !code_o.valid || !code_o.child_digits[DigitW-1], "first child digit out of range")

endmodule

`default_nettype wire
